### sv/hkns_pkg.sv
// Types, codes and constants shared by the hotkey-or-number selector.
package hkns_pkg;

    localparam int unsigned KEY_W   = 8;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned DATA_W  = 64;

    localparam logic [KEY_W-1:0] KEY_BS    = 8'h08;
    localparam logic [KEY_W-1:0] KEY_ENTER = 8'h0D;
    localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;
    localparam logic [KEY_W-1:0] KEY_HIGH  = 8'h60;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] DIGIT_MAX = 4'hF;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    typedef enum logic [2:0] {
        OUT_PENDING = 3'd0,
        OUT_ABORTED = 3'd1,
        OUT_KEY     = 3'd2,
        OUT_NUMBER  = 3'd3,
        OUT_EMPTY   = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        CFG_ACCEPT_LOW  = 2'd0,
        CFG_ACCEPT_HIGH = 2'd1,
        CFG_MAX_VALUE   = 2'd2,
        CFG_CONFIRM     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             abort_flag;
    } t_in_item;

    typedef struct packed {
        t_outcome           outcome;
        logic [VALUE_W-1:0] value;
        logic               echo_valid;
        logic [KEY_W-1:0]   echo_char;
        logic               erase_echo;
    } t_out_item;

    typedef struct packed {
        logic [63:0]        accept_set_low;
        logic [31:0]        accept_set_high;
        logic [VALUE_W-1:0] max_value;
        logic               confirm_keys;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] number_so_far;
        logic [COUNT_W-1:0] digit_count;
        logic               waiting_confirm;
        logic [KEY_W-1:0]   pending_key;
    } t_state;

endpackage

### sv/hkns_step.sv
// Next-state and result logic for one key of the prompt.
module hkns_step (
    input  hkns_pkg::t_cfg      i_cfg,
    input  hkns_pkg::t_state    i_state,
    input  hkns_pkg::t_in_item  i_item,
    output hkns_pkg::t_state    o_state,
    output hkns_pkg::t_out_item o_result
);
    import hkns_pkg::*;

    logic [KEY_W-1:0]   w_key;
    logic               w_numbers_on;
    logic               w_in_set;
    logic [6:0]         w_low_off;
    logic [34:0]        w_appended;
    logic [VALUE_W-1:0] w_next;
    logic [34:0]        w_next_x10;
    logic               w_fits;
    logic               w_digit_ok;
    logic [63:0]        w_prod;
    logic [VALUE_W-1:0] w_quot;

    assign w_key        = i_item.key_code;
    assign w_numbers_on = (i_cfg.max_value != '0);

    // Accepted set covers 0x20..0x7F only
    assign w_low_off = w_key[6:0] - KEY_SPACE[6:0];
    always_comb begin
        w_in_set = 1'b0;
        if (!w_key[7] && (w_key >= KEY_SPACE)) begin
            if (w_key < KEY_HIGH) begin
                w_in_set = i_cfg.accept_set_low[w_low_off[5:0]];
            end else begin
                w_in_set = i_cfg.accept_set_high[w_key[4:0]];
            end
        end
    end

    // number * 10 + digit, and the next step's x10 for auto-complete
    assign w_appended = {1'b0, i_state.number_so_far, 3'b000}
                      + {3'b000, i_state.number_so_far, 1'b0}
                      + {31'd0, w_key[3:0]};
    assign w_fits     = (w_appended <= {4'd0, i_cfg.max_value});
    assign w_next     = w_appended[VALUE_W-1:0];
    assign w_next_x10 = {1'b0, w_next, 3'b000} + {3'b000, w_next, 1'b0};

    assign w_digit_ok = w_numbers_on && (w_key >= KEY_ZERO) && (w_key <= KEY_NINE)
                      && w_fits
                      && ((w_key != KEY_ZERO) || (i_state.digit_count != '0));

    // Drop the last digit: divide by ten through the reciprocal
    assign w_prod = {1'b0, i_state.number_so_far} * DIV10_RECIP;
    assign w_quot = VALUE_W'(w_prod >> DIV10_SHIFT);

    always_comb begin
        o_state             = i_state;
        o_result.outcome    = OUT_PENDING;
        o_result.value      = '0;
        o_result.echo_valid = 1'b0;
        o_result.echo_char  = '0;
        o_result.erase_echo = 1'b0;

        if (i_state.waiting_confirm) begin
            if (i_item.abort_flag) begin
                o_result.outcome = OUT_ABORTED;
            end else if (w_key == KEY_ENTER) begin
                o_result.outcome = OUT_KEY;
                o_result.value   = VALUE_W'(i_state.pending_key);
            end else if (w_key == KEY_BS) begin
                o_state.waiting_confirm = 1'b0;
                o_result.erase_echo     = 1'b1;
            end
        end else if (w_numbers_on && w_key[7]) begin
            // wide key while numbers are on: drop it, abort included
        end else if (i_item.abort_flag) begin
            o_result.outcome = OUT_ABORTED;
        end else if ((i_state.digit_count == '0) && w_in_set) begin
            o_result.echo_valid = 1'b1;
            o_result.echo_char  = w_key;
            if (i_cfg.confirm_keys && (w_key > KEY_SPACE)) begin
                o_state.waiting_confirm = 1'b1;
                o_state.pending_key     = w_key;
            end else begin
                o_result.outcome = OUT_KEY;
                o_result.value   = VALUE_W'(w_key);
            end
        end else if ((w_key == KEY_ENTER) && w_numbers_on) begin
            if (i_state.digit_count != '0) begin
                o_result.outcome = OUT_NUMBER;
                o_result.value   = i_state.number_so_far;
            end else begin
                o_result.outcome = OUT_EMPTY;
            end
        end else if ((w_key == KEY_BS) && (i_state.digit_count != '0)) begin
            o_result.erase_echo   = 1'b1;
            o_state.number_so_far = w_quot;
            o_state.digit_count   = i_state.digit_count - 1'b1;
        end else if (w_digit_ok) begin
            o_state.number_so_far = w_next;
            if (i_state.digit_count != DIGIT_MAX) begin
                o_state.digit_count = i_state.digit_count + 1'b1;
            end
            o_result.echo_valid = 1'b1;
            o_result.echo_char  = w_key;
            if ((w_next_x10 > {4'd0, i_cfg.max_value}) && !i_cfg.confirm_keys) begin
                o_result.outcome = OUT_NUMBER;
                o_result.value   = w_next;
            end
        end

        // A settled prompt starts afresh
        if (o_result.outcome != OUT_PENDING) begin
            o_state.number_so_far   = '0;
            o_state.digit_count     = '0;
            o_state.waiting_confirm = 1'b0;
        end
    end

endmodule

### sv/hotkey_or_number_selector.sv
// Top level of the hotkey-or-number selector: handshakes, registers and state.
// Takes one upper-cased key per cycle while the consumer keeps up, and returns one result item per key.
// A key accepted into the input register moves on to the result register,
// where it is offered, whenever the result register is empty or its item is
// being taken by the consumer.
// The prompt state loop (number so far, digit count, pending hotkey) closes
// through the step logic alone, so keys may arrive on every clock while the
// consumer keeps up, and one more key is still taken into the input register
// while a result waits for the consumer.
// Configuration writes are accepted on any cycle and take effect at once.
module hotkey_or_number_selector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  hkns_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output hkns_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  hkns_pkg::t_cfg_idx           i_cfg_index,
    input  logic [hkns_pkg::DATA_W-1:0]  i_cfg_data
);
    import hkns_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_vld;
    logic      w_advance;

    assign w_advance   = !r_out_vld || i_out_ready;
    assign o_in_ready  = !r_in_vld || w_advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    hkns_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_state   <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ACCEPT_LOW:  r_cfg.accept_set_low  <= i_cfg_data;
                    CFG_ACCEPT_HIGH: r_cfg.accept_set_high <= i_cfg_data[31:0];
                    CFG_MAX_VALUE:   r_cfg.max_value       <= i_cfg_data[VALUE_W-1:0];
                    CFG_CONFIRM:     r_cfg.confirm_keys    <= i_cfg_data[0];
                endcase
            end

            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end

            // Advance the held item into the result register
            if (w_advance) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // Leading zeros are refused, so a 31-bit number has at most ten digits
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digit_count <= 4'd10)
        else $error("digit count beyond ten");

    a_confirm_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.waiting_confirm |-> (r_state.digit_count == '0))
        else $error("confirmation awaited with digits typed");

    a_settle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_vld && (n_out.outcome != OUT_PENDING))
        |=> ((r_state.digit_count == '0) && !r_state.waiting_confirm
             && (r_state.number_so_far == '0)))
        else $error("prompt state kept after a settled outcome");

    a_echo_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.echo_valid) |-> (r_out.echo_char != '0))
        else $error("echo flagged with no character");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && r_in_vld) |=> $stable(r_state))
        else $error("prompt state moved with no item processed");

endmodule
